/* rtl/core/ipd_pkg.sv */
// ----------------------------------------------------------------------------
// ipd_pkg
// Shared widths, register indexes, reset values and types for the
// incremental PI controller with error deadband.
// ----------------------------------------------------------------------------
package ipd_pkg;

  localparam int unsigned SPEED_W    = 16;  // measured and target speed
  localparam int unsigned ERR_W      = 17;  // target - measured, exact
  localparam int unsigned PREV_W     = 18;  // stored previous error
  localparam int unsigned DRIVE_W    = 17;  // reported drive
  localparam int unsigned GAIN_W     = 16;
  localparam int unsigned DB_W       = 15;
  localparam int unsigned LIM_W      = 16;
  localparam int unsigned SEL_W      = 1;
  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [GAIN_W-1:0] KP_RESET       = GAIN_W'(400);
  localparam logic [GAIN_W-1:0] KI_RESET       = GAIN_W'(300);
  localparam logic [DB_W-1:0]   DEADBAND_RESET = DB_W'(41);
  localparam logic [LIM_W-1:0]  LIMIT_RESET    = LIM_W'(7200);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GAIN_PROPORTIONAL = 8'd0,
    CFG_GAIN_INTEGRAL     = 8'd1,
    CFG_ERROR_DEADBAND    = 8'd2,
    CFG_DRIVE_CLAMP       = 8'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [GAIN_W-1:0] gain_proportional;
    logic [GAIN_W-1:0] gain_integral;
    logic [DB_W-1:0]   error_deadband;
    logic [LIM_W-1:0]  drive_clamp;
  } cfg_t;

endpackage

/* rtl/core/ipd_if.sv */
// ----------------------------------------------------------------------------
// ipd_if
// Valid/ready channel interfaces: input items, result items and
// configuration writes.
// ----------------------------------------------------------------------------
interface ipd_in_if;
  logic                                     valid;
  logic                                     ready;
  logic [ipd_pkg::SEL_W-1:0]                motor_select;
  logic signed [ipd_pkg::SPEED_W-1:0]       measured_speed;
  logic signed [ipd_pkg::SPEED_W-1:0]       target_speed;

  modport source (output valid, motor_select, measured_speed, target_speed,
                  input ready);
  modport sink   (input valid, motor_select, measured_speed, target_speed,
                  output ready);
endinterface

interface ipd_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [ipd_pkg::DRIVE_W-1:0]   drive_value;

  modport source (output valid, drive_value, input ready);
  modport sink   (input valid, drive_value, output ready);
endinterface

interface ipd_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [ipd_pkg::CFG_IDX_W-1:0]      index;
  logic [ipd_pkg::CFG_DATA_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/core/ipd_cfg_regs.sv */
// ----------------------------------------------------------------------------
// ipd_cfg_regs
// Configuration register file: gains, deadband and drive clamp.
// ----------------------------------------------------------------------------
module ipd_cfg_regs (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  ipd_cfg_if.sink              cfg_i,
  output ipd_pkg::cfg_t        cfg_o
);

  ipd_pkg::cfg_t cfg_q, cfg_d;

  assign cfg_i.ready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      case (cfg_i.index)
        ipd_pkg::CFG_GAIN_PROPORTIONAL: cfg_d.gain_proportional = cfg_i.data;
        ipd_pkg::CFG_GAIN_INTEGRAL:     cfg_d.gain_integral     = cfg_i.data;
        ipd_pkg::CFG_ERROR_DEADBAND:
          cfg_d.error_deadband = cfg_i.data[ipd_pkg::DB_W-1:0];
        ipd_pkg::CFG_DRIVE_CLAMP:       cfg_d.drive_clamp       = cfg_i.data;
        default: ;  // unknown index: ignored
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gain_proportional <= ipd_pkg::KP_RESET;
      cfg_q.gain_integral     <= ipd_pkg::KI_RESET;
      cfg_q.error_deadband    <= ipd_pkg::DEADBAND_RESET;
      cfg_q.drive_clamp       <= ipd_pkg::LIMIT_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* rtl/core/ipd_update.sv */
// ----------------------------------------------------------------------------
// ipd_update
// One controller step: error, deadband test, PI increment, clamp and
// truncation toward zero of the drive.
// ----------------------------------------------------------------------------
module ipd_update #(
  parameter int unsigned SPEED_FRAC_BITS = 12,
  parameter int unsigned ACC_W           = 30
) (
  input  ipd_pkg::cfg_t                        cfg_i,
  input  logic signed [ipd_pkg::SPEED_W-1:0]   measured_speed_i,
  input  logic signed [ipd_pkg::SPEED_W-1:0]   target_speed_i,
  input  logic signed [ACC_W-1:0]              acc_i,
  input  logic signed [ipd_pkg::PREV_W-1:0]    prev_i,
  output logic signed [ACC_W-1:0]              acc_o,
  output logic signed [ipd_pkg::PREV_W-1:0]    prev_o,
  output logic signed [ipd_pkg::DRIVE_W-1:0]   drive_o
);

  localparam int unsigned DIFF_W = ipd_pkg::PREV_W + 1;
  localparam int unsigned P_W    = ipd_pkg::GAIN_W + 1 + DIFF_W;
  localparam int unsigned I_W    = ipd_pkg::GAIN_W + 1 + ipd_pkg::ERR_W;
  localparam int unsigned SUM_W  = ((ACC_W > P_W) ? ACC_W : P_W) + 2;

  logic signed [ipd_pkg::ERR_W-1:0]  err;
  logic        [ipd_pkg::ERR_W-1:0]  err_mag;
  logic                              in_band;
  logic signed [DIFF_W-1:0]          diff;
  logic signed [P_W-1:0]             p_term;
  logic signed [I_W-1:0]             i_term;
  logic signed [SUM_W-1:0]           sum;
  logic signed [SUM_W-1:0]           lim;
  logic signed [SUM_W-1:0]           clamped;
  logic signed [ACC_W-1:0]           acc_next;
  logic        [ACC_W-1:0]           acc_mag;
  logic        [ipd_pkg::LIM_W-1:0]  drive_mag;

  assign err     = ipd_pkg::ERR_W'(target_speed_i) - ipd_pkg::ERR_W'(measured_speed_i);
  assign err_mag = err[ipd_pkg::ERR_W-1] ? -err : err;
  // edge of the deadband counts as outside
  assign in_band = err_mag < {{(ipd_pkg::ERR_W-ipd_pkg::DB_W){1'b0}}, cfg_i.error_deadband};

  assign diff   = DIFF_W'(err) - DIFF_W'(prev_i);
  assign p_term = P_W'($signed({1'b0, cfg_i.gain_proportional})) * P_W'(diff);
  assign i_term = I_W'($signed({1'b0, cfg_i.gain_integral})) * I_W'(err);

  assign sum = SUM_W'(acc_i) + SUM_W'(p_term) + SUM_W'(i_term);
  assign lim = $signed(SUM_W'({cfg_i.drive_clamp, {SPEED_FRAC_BITS{1'b0}}}));

  always_comb begin
    if (sum > lim) begin
      clamped = lim;
    end else if (sum < -lim) begin
      clamped = -lim;
    end else begin
      clamped = sum;
    end
  end

  assign acc_next = in_band ? acc_i : ACC_W'(clamped);

  // |acc| never exceeds 65535 << SPEED_FRAC_BITS
  assign acc_mag   = acc_next[ACC_W-1] ? -acc_next : acc_next;
  assign drive_mag = acc_mag[SPEED_FRAC_BITS +: ipd_pkg::LIM_W];
  assign drive_o   = acc_next[ACC_W-1] ? -$signed({1'b0, drive_mag})
                                       :  $signed({1'b0, drive_mag});

  assign acc_o  = acc_next;
  assign prev_o = ipd_pkg::PREV_W'(err);

endmodule

/* rtl/core/incremental_pi_deadband.sv */
// ----------------------------------------------------------------------------
// incremental_pi_deadband
// Multi-channel incremental PI speed controller with an error deadband and
// a symmetric drive clamp.
// ----------------------------------------------------------------------------
//  channel | dir | payload                                      | accept
//  in_i    | in  | motor_select, measured_speed, target_speed   | valid & ready
//  out_o   | out | drive_value                                  | valid & ready
//  cfg_i   | in  | index, data (register write)                 | valid & ready
//
//  One transaction per cycle sustained while results are accepted. Results
//  pass the input register, then the combinational PI step, which is written
//  into the result register together with the per-channel state.
//  Per-channel state updates in the same cycle it is read, so consecutive
//  transactions on one channel see each other's result.
//  rst_ni clears the valid flags and the per-channel state and loads the register reset values.
//  A stalled result holds the pipeline; an empty input register still fills.
// ----------------------------------------------------------------------------
module incremental_pi_deadband #(
  parameter int unsigned CHANNELS        = 2,
  parameter int unsigned SPEED_FRAC_BITS = 12
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  ipd_in_if.sink    in_i,
  ipd_out_if.source out_o,
  ipd_cfg_if.sink   cfg_i
);

  localparam int unsigned ACC_W = ipd_pkg::LIM_W + SPEED_FRAC_BITS + 2;
  // the select field reaches at most two channels
  localparam int unsigned NCH   = (CHANNELS < 2) ? CHANNELS : 2;

  ipd_pkg::cfg_t cfg;

  logic                                   in_valid_q;
  logic [ipd_pkg::SEL_W-1:0]              sel_q;
  logic signed [ipd_pkg::SPEED_W-1:0]     measured_q;
  logic signed [ipd_pkg::SPEED_W-1:0]     target_q;

  logic                                   out_valid_q;
  logic signed [ipd_pkg::DRIVE_W-1:0]     drive_q, drive_d;

  logic signed [ACC_W-1:0]                acc_q  [NCH];
  logic signed [ipd_pkg::PREV_W-1:0]      prev_q [NCH];

  logic signed [ACC_W-1:0]                acc_cur, acc_new;
  logic signed [ipd_pkg::PREV_W-1:0]      prev_cur, prev_new;
  logic signed [ipd_pkg::DRIVE_W-1:0]     drive_new;
  logic                                   ch_ok;
  logic                                   advance;
  logic                                   in_fire;

  ipd_cfg_regs u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  assign advance     = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready  = !in_valid_q || advance;
  assign in_fire     = in_i.valid && in_i.ready;

  assign ch_ok = {{(32-ipd_pkg::SEL_W){1'b0}}, sel_q} < CHANNELS;

  always_comb begin
    acc_cur  = '0;
    prev_cur = '0;
    for (int i = 0; i < NCH; i++) begin
      if (sel_q == ipd_pkg::SEL_W'(i)) begin
        acc_cur  = acc_q[i];
        prev_cur = prev_q[i];
      end
    end
  end

  ipd_update #(
    .SPEED_FRAC_BITS (SPEED_FRAC_BITS),
    .ACC_W           (ACC_W)
  ) u_update (
    .cfg_i            (cfg),
    .measured_speed_i (measured_q),
    .target_speed_i   (target_q),
    .acc_i            (acc_cur),
    .prev_i           (prev_cur),
    .acc_o            (acc_new),
    .prev_o           (prev_new),
    .drive_o          (drive_new)
  );

  assign drive_d = ch_ok ? drive_new : '0;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      sel_q      <= in_i.motor_select;
      measured_q <= in_i.measured_speed;
      target_q   <= in_i.target_speed;
    end
  end

  // per-channel controller state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NCH; i++) begin
        acc_q[i]  <= '0;
        prev_q[i] <= '0;
      end
    end else if (advance && ch_ok) begin
      for (int i = 0; i < NCH; i++) begin
        if (sel_q == ipd_pkg::SEL_W'(i)) begin
          acc_q[i]  <= acc_new;
          prev_q[i] <= prev_new;
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      drive_q <= drive_d;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.drive_value = drive_q;

endmodule

/* tb/sv/tb_incremental_pi_deadband.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_incremental_pi_deadband
// Self-checking bench for the two-channel incremental PI controller. A
// scoreboard class mirrors the per-channel drive and error state and
// predicts each drive value. Directed items cover the deadband edge, clamp
// extremes and a lowered limit. Random phases follow under several register
// settings, with random idling on the input and output channels.
// ----------------------------------------------------------------------------
module tb_incremental_pi_deadband;
  import ipd_pkg::*;

  localparam int unsigned CLK_HALF    = 5;
  localparam int unsigned FRAC_BITS   = 12;
  localparam int unsigned NUM_CH      = 2;
  localparam int unsigned GAP_PCT     = 38;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned NUM_PHASES  = 8;
  localparam int unsigned PHASE_ITEMS = 168;
  localparam int unsigned MAX_REPORTS = 10;

  localparam logic [CFG_IDX_W-1:0]     CFG_UNMAPPED = 8'hA5;
  localparam logic signed [SPEED_W-1:0] SPEED_MAX   = 16'sh7FFF;
  localparam logic signed [SPEED_W-1:0] SPEED_MIN   = 16'sh8000;
  localparam logic signed [SPEED_W-1:0] SPEED_NEG1  = 16'shFFFF;

  class drive_scoreboard;
    logic [GAIN_W-1:0]         kp;
    logic [GAIN_W-1:0]         ki;
    logic [DB_W-1:0]           deadband;
    logic [LIM_W-1:0]          limit;
    longint                    acc [NUM_CH];
    longint                    last_err [NUM_CH];
    logic signed [DRIVE_W-1:0] drive_q [$];
    int unsigned               failures;

    function new();
      kp       = KP_RESET;
      ki       = KI_RESET;
      deadband = DEADBAND_RESET;
      limit    = LIMIT_RESET;
      foreach (acc[i]) begin
        acc[i]      = 0;
        last_err[i] = 0;
      end
      failures = 0;
    endfunction

    function void write_reg(input logic [CFG_IDX_W-1:0] idx,
                            input logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_GAIN_PROPORTIONAL: kp       = data[GAIN_W-1:0];
        CFG_GAIN_INTEGRAL:     ki       = data[GAIN_W-1:0];
        CFG_ERROR_DEADBAND:    deadband = data[DB_W-1:0];
        CFG_DRIVE_CLAMP:       limit    = data[LIM_W-1:0];
        default: ;
      endcase
    endfunction

    function void note_input(input logic [SEL_W-1:0] sel,
                             input logic signed [SPEED_W-1:0] meas,
                             input logic signed [SPEED_W-1:0] tgt);
      longint err, mag, sum, lim, drv;
      int     ch;
      ch = int'(sel);
      if (ch >= NUM_CH) begin
        drive_q.push_back('0);
        return;
      end
      err = longint'(tgt) - longint'(meas);
      mag = (err < 0) ? -err : err;
      if (mag >= longint'(deadband)) begin
        sum = acc[ch] + longint'(kp) * (err - last_err[ch]) + longint'(ki) * err;
        lim = longint'(limit) <<< FRAC_BITS;
        if (sum > lim)  sum = lim;
        if (sum < -lim) sum = -lim;
        acc[ch] = sum;
      end
      last_err[ch] = err;
      // truncate toward zero
      drv = (acc[ch] < 0) ? -((-acc[ch]) >>> FRAC_BITS) : (acc[ch] >>> FRAC_BITS);
      drive_q.push_back(DRIVE_W'(drv));
    endfunction

    function void report(input string msg);
      failures++;
      if (failures <= MAX_REPORTS) $display("%s", msg);
    endfunction

    function void check_drive(input logic signed [DRIVE_W-1:0] actual);
      logic signed [DRIVE_W-1:0] want;
      if (drive_q.size() == 0) begin
        report($sformatf("unexpected drive transaction: actual %0d", actual));
        return;
      end
      want = drive_q.pop_front();
      if (actual !== want)
        report($sformatf("drive_value mismatch: expected %0d actual %0d", want, actual));
    endfunction

    function int pending();
      return drive_q.size();
    endfunction
  endclass

  logic clk   = 1'b0;
  logic rst_n = 1'b0;
  bit   gaps_on = 1'b1;
  int unsigned idle_cycles = 0;
  drive_scoreboard sb;

  logic [CFG_DATA_W-1:0] ph_kp  [5] = '{16'd400, 16'd0, 16'hFFFF, 16'hFFFF, 16'd1};
  logic [CFG_DATA_W-1:0] ph_ki  [5] = '{16'd300, 16'd0, 16'hFFFF, 16'hFFFF, 16'd1};
  logic [CFG_DATA_W-1:0] ph_db  [5] = '{16'd41,  16'd0, 16'h7FFF, 16'd0,    16'd0};
  logic [CFG_DATA_W-1:0] ph_lim [5] = '{16'd7200, 16'd0, 16'hFFFF, 16'hFFFF, 16'd1};

  ipd_in_if  in_ch ();
  ipd_out_if out_ch ();
  ipd_cfg_if cfg_ch ();

  incremental_pi_deadband #(
    .CHANNELS        (NUM_CH),
    .SPEED_FRAC_BITS (FRAC_BITS)
  ) i_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_ch),
    .out_o  (out_ch),
    .cfg_i  (cfg_ch)
  );

  always #CLK_HALF clk = ~clk;

  always @(negedge clk) begin
    out_ch.ready <= !gaps_on || ($urandom_range(99) >= GAP_PCT);
  end

  // sample all channels at the rising edge; watchdog on accept-free cycles
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) sb.check_drive(out_ch.drive_value);
      if (in_ch.valid && in_ch.ready)
        sb.note_input(in_ch.motor_select, in_ch.measured_speed, in_ch.target_speed);
      if (cfg_ch.valid && cfg_ch.ready) sb.write_reg(cfg_ch.index, cfg_ch.data);
      if ((out_ch.valid && out_ch.ready) || (in_ch.valid && in_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= STALL_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  task automatic send_item(input logic [SEL_W-1:0] sel,
                           input logic signed [SPEED_W-1:0] meas,
                           input logic signed [SPEED_W-1:0] tgt);
    while (gaps_on && $urandom_range(99) < GAP_PCT) begin
      in_ch.valid          <= 1'b0;
      in_ch.motor_select   <= SEL_W'($urandom);
      in_ch.measured_speed <= SPEED_W'($urandom);
      in_ch.target_speed   <= SPEED_W'($urandom);
      @(negedge clk);
    end
    in_ch.valid          <= 1'b1;
    in_ch.motor_select   <= sel;
    in_ch.measured_speed <= meas;
    in_ch.target_speed   <= tgt;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic cfg_put(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // writes all registers plus one unmapped index, which must be ignored
  task automatic program_regs(input logic [CFG_DATA_W-1:0] kp, input logic [CFG_DATA_W-1:0] ki,
                              input logic [CFG_DATA_W-1:0] db, input logic [CFG_DATA_W-1:0] lim);
    cfg_put(CFG_GAIN_PROPORTIONAL, kp);
    cfg_put(CFG_UNMAPPED, CFG_DATA_W'($urandom));
    cfg_put(CFG_GAIN_INTEGRAL, ki);
    cfg_put(CFG_ERROR_DEADBAND, db);
    cfg_put(CFG_DRIVE_CLAMP, lim);
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic logic signed [SPEED_W-1:0] pick_extreme();
    case ($urandom_range(3))
      0:       return SPEED_MIN;
      1:       return SPEED_MAX;
      2:       return '0;
      default: return SPEED_NEG1;
    endcase
  endfunction

  task automatic send_random();
    logic [SEL_W-1:0]          sel;
    logic signed [SPEED_W-1:0] meas, tgt;
    int                        span, d, t;
    sel  = SEL_W'($urandom);
    meas = SPEED_W'($urandom);
    tgt  = SPEED_W'($urandom);
    span = int'(sb.deadband) + 4;
    case ($urandom_range(9))
      0, 1: ;
      2: begin
        meas = pick_extreme();
        tgt  = pick_extreme();
      end
      3, 4: begin
        d = int'($urandom_range(600)) - 300;
        t = int'(meas) + d;
      end
      default: begin
        // error straddling the deadband edge
        d = int'($urandom_range(2 * span)) - span;
        t = int'(meas) + d;
      end
    endcase
    if (d != 0 || t != 0) begin
      if (t > int'(SPEED_MAX)) t = int'(SPEED_MAX);
      if (t < int'(SPEED_MIN)) t = int'(SPEED_MIN);
      tgt = t[SPEED_W-1:0];
    end
    send_item(sel, meas, tgt);
  endtask

  initial begin
    sb = new();
    in_ch.valid          = 1'b0;
    in_ch.motor_select   = '0;
    in_ch.measured_speed = '0;
    in_ch.target_speed   = '0;
    cfg_ch.valid         = 1'b0;
    cfg_ch.index         = '0;
    cfg_ch.data          = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset values: deadband edge, saturation, held drive
    send_item(1'b0, 16'sd0, 16'sd0);
    send_item(1'b1, 16'sd0, 16'sd0);
    send_item(1'b0, 16'sd0, 16'sd41);
    send_item(1'b0, 16'sd0, 16'sd40);
    send_item(1'b1, 16'sd100, 16'sd59);
    send_item(1'b0, SPEED_MIN, SPEED_MAX);
    send_item(1'b0, SPEED_MIN, SPEED_MAX);
    send_item(1'b1, SPEED_MAX, SPEED_MIN);
    send_item(1'b0, 16'sd5, 16'sd5);
    send_item(1'b1, SPEED_MAX, SPEED_MAX);
    wait_drained();

    // lowered limit: held drive reported until next PI update clamps it
    program_regs(16'd400, 16'd300, 16'd41, 16'd1000);
    send_item(1'b0, 16'sd10, 16'sd20);
    send_item(1'b1, 16'sd0, 16'sd0);
    send_item(1'b0, 16'sd0, 16'sd100);
    send_item(1'b1, 16'sd0, -16'sd100);
    wait_drained();

    program_regs(16'd0, 16'd0, 16'd0, 16'd0);
    send_item(1'b0, 16'sd0, 16'sd0);
    send_item(1'b1, SPEED_MIN, SPEED_MAX);
    wait_drained();

    // deadband write with bit 15 set; only 15 bits are kept
    program_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_item(1'b0, SPEED_MIN, SPEED_MAX);
    send_item(1'b1, 16'sd0, 16'sd32766);
    send_item(1'b0, 16'sd0, -16'sd32767);
    send_item(1'b1, SPEED_MAX, SPEED_MIN);
    send_item(1'b0, SPEED_NEG1, SPEED_MIN);

    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_drained();
      if (p < 5) begin
        program_regs(ph_kp[p], ph_ki[p], ph_db[p], ph_lim[p]);
      end else begin
        program_regs(CFG_DATA_W'($urandom), CFG_DATA_W'($urandom),
                     CFG_DATA_W'($urandom_range(600)), CFG_DATA_W'($urandom));
      end
      gaps_on = (p != 3);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n == PHASE_ITEMS / 2) wait_drained();
        send_random();
      end
    end
    gaps_on = 1'b1;
    wait_drained();

    if (sb.failures == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
